// ===== hw/rtl/ppg_pkg.sv =====
// ----------------------------------------------------------------------------
// Poisson PMF generator package
// Widths, working fixed-point format and the exp(-2^(j-F)) constant table.
// ----------------------------------------------------------------------------
package ppg_pkg;

  localparam int MEAN_FRAC_BITS = 12;
  localparam int PROB_BITS      = 32;
  localparam int MAX_TERMS      = 64;

  localparam int MEAN_W       = 16;
  localparam int IDX_W        = 6;
  localparam int WORK_W       = 64;
  localparam int WORK_FRAC    = 60;
  localparam int TAYLOR_TERMS = 10;
  localparam int MUL_DIG_W    = 16;
  localparam int MUL_DIGITS   = WORK_W / MUL_DIG_W;

  typedef logic [WORK_W-1:0] work_t;
  typedef work_t exp_tab_t [MEAN_W];

  localparam work_t WORK_ONE = work_t'(1) << WORK_FRAC;

  // Shift right, saturate to all ones when the result overflows the work width
  function automatic work_t sat_shr(input logic [2*WORK_W-1:0] v, input int unsigned sh);
    logic [2*WORK_W-1:0] s;
    s = v >> sh;
    if (|s[2*WORK_W-1:WORK_W]) return '1;
    return s[WORK_W-1:0];
  endfunction

  // Long division by a small constant, one quotient bit per step
  function automatic work_t taylor_div(input work_t v, input int unsigned n);
    work_t      q;
    logic [7:0] r;
    q = '0;
    r = '0;
    for (int i = WORK_W - 1; i >= 0; i--) begin
      r = {r[6:0], v[i]};
      if (r >= 8'(n)) begin
        r    = r - 8'(n);
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-2^-F) from its Taylor series, each higher entry the square of the one below
  function automatic exp_tab_t calc_exp_tab();
    work_t    x;
    work_t    term;
    work_t    sum;
    work_t    c;
    exp_tab_t tab;
    x    = work_t'(1) << (WORK_FRAC - MEAN_FRAC_BITS);
    term = WORK_ONE;
    sum  = WORK_ONE;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = taylor_div(sat_shr({{WORK_W{1'b0}}, term} * {{WORK_W{1'b0}}, x}, WORK_FRAC),
                        n);
      if ((n & 1) != 0) sum = sum - term;
      else              sum = sum + term;
    end
    c = sum;
    for (int j = 0; j < MEAN_W; j++) begin
      tab[j] = c;
      c = sat_shr({{WORK_W{1'b0}}, c} * {{WORK_W{1'b0}}, c}, WORK_FRAC);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_C = calc_exp_tab();

endpackage

// ===== hw/rtl/poisson_pmf_generator_top.sv =====
// ----------------------------------------------------------------------------
// Poisson PMF generator
// Emits p(k) = exp(-mean) * mean^k / k! for a Poisson mean in UQ4.12.
// ----------------------------------------------------------------------------
// Usage: present a mean on mean_i with in_valid_i; the transaction completes
// when in_stall_o is low. The block then emits floor(4*mean+10) results,
// capped at MAX_TERMS-1, on the output channel (out_valid_o / out_stall_i),
// each carrying k, p(k) in UQ0.32, and last_term_o on the final one. A zero
// mean gives a single result with invalid_mean_o set.
// A shared 64x16 multiplier (one digit per cycle) and a radix-2 divider do
// all the arithmetic. exp(-mean) scans the 16 mean bits and multiplies by
// the table constant of each set bit before the first result is loaded.
// Each later term is a multiply by the mean, a divide by k+1 and a load.
// in_stall_o stays high from acceptance until the last result has been
// loaded into the output register; the next mean may enter while it waits.
// A stalled receiver holds the output register and the sequencer waits
// before loading the next term. Reset clears the sequencer and the output
// valid; no clearing pass is needed.
module poisson_pmf_generator_top import ppg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [MEAN_W-1:0]    mean_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IDX_W-1:0]     term_index_o,
  output logic [PROB_BITS-1:0] probability_o,
  output logic                 invalid_mean_o,
  output logic                 last_term_o
);

  localparam int BIT_W     = $clog2(MEAN_W) + 1;
  localparam int MUL_CNT_W = $clog2(MUL_DIGITS + 2);
  localparam int DIV_CNT_W = $clog2(WORK_W);
  localparam int PP_W      = WORK_W + MUL_DIG_W;
  localparam int ACC_W     = 2 * WORK_W;
  localparam int CNT_SUM_W = MEAN_W + 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP,
    ST_MUL,
    ST_DIV,
    ST_EMIT,
    ST_ERR
  } state_e;

  state_e                 state_q;
  logic [MEAN_W-1:0]      mean_q;
  logic [IDX_W-1:0]       count_q;
  logic [IDX_W-1:0]       k_q;
  logic [BIT_W-1:0]       bit_q;
  work_t                  p_q;
  work_t                  mul_a_q;
  work_t                  mul_b_q;
  logic [MUL_CNT_W-1:0]   mul_cnt_q;
  logic [PP_W-1:0]        pp_q;
  logic [ACC_W-1:0]       acc_q;
  logic                   exp_phase_q;
  logic [DIV_CNT_W-1:0]   div_cnt_q;
  work_t                  quo_q;
  logic [IDX_W-1:0]       rem_q;
  logic                   out_valid_q;
  logic [IDX_W-1:0]       out_index_q;
  logic [PROB_BITS-1:0]   out_prob_q;
  logic                   out_invalid_q;
  logic                   out_last_q;

  logic [CNT_SUM_W-1:0]   cnt_sum;
  logic [CNT_SUM_W-1:0]   cnt_full;
  logic [IDX_W-1:0]       cnt_cap;
  work_t                  mul_res;
  logic [IDX_W-1:0]       divisor;
  logic [IDX_W:0]         rem_sh;
  logic                   div_ge;
  logic [IDX_W-1:0]       rem_next;
  logic                   out_free;
  logic                   out_load;
  logic                   last_hit;
  logic [PROB_BITS-1:0]   prob_val;
  work_t                  p_clamp;

  // Term count: floor((4*mean + 10*2^F) / 2^F), capped
  always_comb begin
    cnt_sum  = (CNT_SUM_W'(mean_i) << 2) + (CNT_SUM_W'(10) << MEAN_FRAC_BITS);
    cnt_full = cnt_sum >> MEAN_FRAC_BITS;
    if (cnt_full > CNT_SUM_W'(MAX_TERMS - 1)) cnt_cap = IDX_W'(MAX_TERMS - 1);
    else                                      cnt_cap = cnt_full[IDX_W-1:0];
  end

  assign mul_res = exp_phase_q ? sat_shr(acc_q, WORK_FRAC) : sat_shr(acc_q, MEAN_FRAC_BITS);

  // Restoring divide step by k+1
  assign divisor  = k_q + IDX_W'(1);
  assign rem_sh   = {rem_q, quo_q[WORK_W-1]};
  assign div_ge   = rem_sh >= {1'b0, divisor};
  assign rem_next = div_ge ? IDX_W'(rem_sh - {1'b0, divisor}) : rem_sh[IDX_W-1:0];

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = out_free && (state_q inside {ST_EMIT, ST_ERR});
  assign last_hit = (k_q + IDX_W'(1)) == count_q;
  assign prob_val = (p_q >= WORK_ONE) ? '1 : p_q[WORK_FRAC-PROB_BITS +: PROB_BITS];
  assign p_clamp  = (p_q > WORK_ONE) ? WORK_ONE : p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mean_q        <= '0;
      count_q       <= '0;
      k_q           <= '0;
      bit_q         <= '0;
      p_q           <= '0;
      mul_a_q       <= '0;
      mul_b_q       <= '0;
      mul_cnt_q     <= '0;
      pp_q          <= '0;
      acc_q         <= '0;
      exp_phase_q   <= 1'b0;
      div_cnt_q     <= '0;
      quo_q         <= '0;
      rem_q         <= '0;
      out_valid_q   <= 1'b0;
      out_index_q   <= '0;
      out_prob_q    <= '0;
      out_invalid_q <= 1'b0;
      out_last_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            mean_q  <= mean_i;
            count_q <= cnt_cap;
            k_q     <= '0;
            bit_q   <= '0;
            p_q     <= WORK_ONE;
            state_q <= (mean_i == '0) ? ST_ERR : ST_EXP;
          end
        end

        ST_EXP: begin
          if (bit_q == BIT_W'(MEAN_W)) begin
            state_q <= ST_EMIT;
          end else if (mean_q[bit_q[BIT_W-2:0]]) begin
            mul_a_q     <= p_q;
            mul_b_q     <= EXP_C[bit_q[BIT_W-2:0]];
            exp_phase_q <= 1'b1;
            mul_cnt_q   <= '0;
            state_q     <= ST_MUL;
          end else begin
            bit_q <= bit_q + BIT_W'(1);
          end
        end

        // Digit-serial multiply, most significant digit of b first
        ST_MUL: begin
          if (mul_cnt_q < MUL_CNT_W'(MUL_DIGITS)) begin
            pp_q    <= PP_W'(mul_a_q) * PP_W'(mul_b_q[WORK_W-1 -: MUL_DIG_W]);
            mul_b_q <= mul_b_q << MUL_DIG_W;
          end
          if (mul_cnt_q == '0) begin
            acc_q <= '0;
          end else if (mul_cnt_q <= MUL_CNT_W'(MUL_DIGITS)) begin
            acc_q <= (acc_q << MUL_DIG_W) + ACC_W'(pp_q);
          end
          mul_cnt_q <= mul_cnt_q + MUL_CNT_W'(1);
          if (mul_cnt_q == MUL_CNT_W'(MUL_DIGITS + 1)) begin
            if (exp_phase_q) begin
              p_q     <= mul_res;
              bit_q   <= bit_q + BIT_W'(1);
              state_q <= ST_EXP;
            end else begin
              quo_q     <= mul_res;
              rem_q     <= '0;
              div_cnt_q <= '0;
              state_q   <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          quo_q     <= {quo_q[WORK_W-2:0], div_ge};
          rem_q     <= rem_next;
          div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
          if (div_cnt_q == DIV_CNT_W'(WORK_W - 1)) begin
            p_q     <= {quo_q[WORK_W-2:0], div_ge};
            k_q     <= k_q + IDX_W'(1);
            state_q <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_index_q   <= k_q;
            out_prob_q    <= prob_val;
            out_invalid_q <= 1'b0;
            out_last_q    <= last_hit;
            if (last_hit) begin
              state_q <= ST_IDLE;
            end else begin
              // clamp to 1.0, then multiply by the mean
              mul_a_q     <= p_clamp;
              mul_b_q     <= WORK_W'(mean_q);
              exp_phase_q <= 1'b0;
              mul_cnt_q   <= '0;
              state_q     <= ST_MUL;
            end
          end
        end

        ST_ERR: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_index_q   <= '0;
            out_prob_q    <= '0;
            out_invalid_q <= 1'b1;
            out_last_q    <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign term_index_o   = out_index_q;
  assign probability_o  = out_prob_q;
  assign invalid_mean_o = out_invalid_q;
  assign last_term_o    = out_last_q;

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_mean_o |-> last_term_o && term_index_o == '0 && probability_o == '0)
    else $error("invalid-mean transaction has wrong shape");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the run started");

  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> (k_q + IDX_W'(1)) < count_q)
    else $error("divide step beyond the last term");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> k_q < count_q)
    else $error("term index beyond the term count");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && out_free && last_hit |=> state_q == ST_IDLE && out_last_q)
    else $error("run did not end on the last term");

endmodule
